// ----- rtl/core/midpoint_circle_rasterizer_top_assert.svh -----
// Assertion macros shared by the circle rasterizer RTL.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mcr_pkg.sv -----
// Shared constants and types for the midpoint circle rasterizer.
package mcr_pkg;

   localparam int COORD_BITS_DEF = 10;
   localparam int QUEUE_DEPTH    = 2;

   // Item kinds carried on the request tuser bit.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Decision value constants of the midpoint iteration.
   localparam int DEC_INIT     = 3;
   localparam int DEC_INC_EAST = 6;
   localparam int DEC_INC_DIAG = 10;

   // Width of the symmetric point index and the index of the final one.
   localparam int         OCT_BITS = 3;
   localparam logic [2:0] OCT_LAST = 3'd7;

   typedef struct packed {
      logic full;
      logic empty;
   } mcr_qstat_type;

endpackage

// ----- rtl/core/mcr_queue.sv -----
// Small register queue between the circle front end and the point emitter.
module mcr_queue #(
   parameter int WIDTH = 42,
   parameter int DEPTH = mcr_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      head_data,
   output mcr_pkg::mcr_qstat_type status
);
   import mcr_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/mcr_front.sv -----
// Front end: accepts items, runs the midpoint iteration and queues point sets.
module mcr_front #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
   localparam int ENTRY_W   = 4 * COORD_BITS + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   kind,
   input  logic [COORD_BITS-1:0]  center_x,
   input  logic [COORD_BITS-1:0]  center_y,
   input  logic [COORD_BITS-2:0]  radius,
   input  mcr_pkg::mcr_qstat_type qstat,
   output logic                   push,
   output logic [ENTRY_W-1:0]     push_data
);
   import mcr_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int DEC_W = CB + 3;

   logic [CB-1:0]    origin_x_ff, origin_x_in;
   logic [CB-1:0]    origin_y_ff, origin_y_in;
   logic [CB:0]      offset_x_ff, offset_x_in;
   logic [CB-1:0]    offset_y_ff, offset_y_in;
   logic [DEC_W-1:0] decision_ff, decision_in;
   logic             active_ff, active_in;

   logic             accept;
   logic [DEC_W-1:0] x_ext, y_ext, dec_init, dec_step;
   logic [CB-1:0]    y_step;
   logic [CB:0]      x_step;
   logic             done_step, done;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;

   // One midpoint iteration from the held state.
   always_comb begin
      x_ext    = {{2{offset_x_ff[CB]}}, offset_x_ff};
      y_ext    = {{3{offset_y_ff[CB-1]}}, offset_y_ff};
      dec_init = DEC_W'(DEC_INIT) - (DEC_W'(radius) << 1);
      if (decision_ff[DEC_W-1]) begin
         dec_step = decision_ff + (x_ext << 2) + DEC_W'(DEC_INC_EAST);
         y_step   = offset_y_ff;
      end else begin
         dec_step = decision_ff + ((x_ext - y_ext) << 2) + DEC_W'(DEC_INC_DIAG);
         y_step   = offset_y_ff - 1'b1;
      end
      x_step    = offset_x_ff + 1'b1;
      done_step = $signed(x_step) > $signed({y_step[CB-1], y_step});
   end

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      push        = 1'b0;
      done        = 1'b0;
      if (accept) begin
         if (kind == KIND_START) begin
            origin_x_in = center_x;
            origin_y_in = center_y;
            offset_x_in = '0;
            offset_y_in = CB'(radius);
            decision_in = dec_init[DEC_W-1:0];
            active_in   = 1'b1;
            push        = 1'b1;
         end else if (active_ff) begin
            offset_x_in = x_step;
            offset_y_in = y_step;
            decision_in = dec_step;
            active_in   = !done_step;
            done        = done_step;
            push        = 1'b1;
         end
      end
   end

   assign push_data = {done, offset_y_in, offset_x_in, origin_y_in, origin_x_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
      end else begin
         active_ff   <= active_in;
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
      end
   end

endmodule

// ----- rtl/core/mcr_back.sv -----
// Back end: walks one queued point set through its eight symmetric points.
module mcr_back #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
   localparam int ENTRY_W   = 4 * COORD_BITS + 2,
   localparam int OUT_W     = COORD_BITS + 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ENTRY_W-1:0]     head_data,
   input  mcr_pkg::mcr_qstat_type qstat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       point_x,
   output logic [OUT_W-1:0]       point_y,
   output logic [2:0]             octant,
   output logic                   last_of_step,
   output logic                   circle_done
);
   import mcr_pkg::*;

   localparam int CB = COORD_BITS;

   logic [CB-1:0]       cx, cy, y_off;
   logic [CB:0]         x_off;
   logic                done_head;
   logic [OUT_W-1:0]    cx_w, cy_w, x_w, y_w, add_x, add_y, px_calc, py_calc;
   logic                swap, neg_x, neg_y, load;

   logic [OCT_BITS-1:0] oct_ff, oct_in;
   logic                valid_ff, valid_in;
   logic [OUT_W-1:0]    px_ff, py_ff;
   logic [OCT_BITS-1:0] oct_out_ff;
   logic                last_ff, done_ff;

   assign {done_head, y_off, x_off, cy, cx} = head_data;

   // Octant order: odd points swap x and y, points four to seven negate
   // the x term, points two to five negate the y term.
   always_comb begin
      cx_w    = {2'b00, cx};
      cy_w    = {2'b00, cy};
      x_w     = {x_off[CB], x_off};
      y_w     = {{2{y_off[CB-1]}}, y_off};
      swap    = oct_ff[0];
      neg_x   = oct_ff[2];
      neg_y   = oct_ff[2] ^ oct_ff[1];
      add_x   = swap ? y_w : x_w;
      add_y   = swap ? x_w : y_w;
      px_calc = neg_x ? cx_w - add_x : cx_w + add_x;
      py_calc = neg_y ? cy_w - add_y : cy_w + add_y;
   end

   assign load     = !qstat.empty && (!valid_ff || rsp_ready);
   assign pop      = load && (oct_ff == OCT_LAST);
   assign oct_in   = load ? oct_ff + 1'b1 : oct_ff;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         oct_ff   <= oct_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff      <= px_calc;
         py_ff      <= py_calc;
         oct_out_ff <= oct_ff;
         last_ff    <= (oct_ff == OCT_LAST);
         done_ff    <= done_head;
      end
   end

   assign rsp_valid    = valid_ff;
   assign point_x      = px_ff;
   assign point_y      = py_ff;
   assign octant       = oct_out_ff;
   assign last_of_step = last_ff;
   assign circle_done  = done_ff;

endmodule

// ----- rtl/core/midpoint_circle_rasterizer_top.sv -----
// Top level of the midpoint circle rasterizer with eight-way symmetry.
//
//   Channel  Direction  tdata (low bit up)                       tuser        tlast
//   req_     in         center_x, center_y, radius               kind         -
//   rsp_     out        point_x, point_y, octant                 circle_done  last_of_step
//
// Every item that starts a circle, or that advances an active one, yields
// eight points, one per cycle while the result port accepts them.
// An advance item with no circle in progress is taken and yields nothing.
// Reset is synchronous and active high. The front end keeps taking items
// while the two-entry queue has room, so a stalled result port only stops
// input once the queue is full.
module midpoint_circle_rasterizer_top #(
   parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF,
   localparam int REQ_W     = ((3 * COORD_BITS - 1 + 7) / 8) * 8,
   localparam int OUT_W     = COORD_BITS + 2,
   localparam int RSP_W     = ((2 * OUT_W + 3 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // center_x, center_y, radius, zero padding
   input  logic             req_tuser,  // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // point_x, point_y, octant, zero padding
   output logic             rsp_tuser,  // circle_done
   output logic             rsp_tlast   // last_of_step
);
   import mcr_pkg::*;

   `include "midpoint_circle_rasterizer_top_assert.svh"

   localparam int ENTRY_W = 4 * COORD_BITS + 2;

   // Unpacked request fields.
   logic [COORD_BITS-1:0] center_x, center_y;
   logic [COORD_BITS-2:0] radius;

   // Queue traffic between the front end and the point emitter.
   mcr_qstat_type         qstat;
   logic                  push, pop;
   logic [ENTRY_W-1:0]    push_data, head_data;

   // Result fields from the emitter's output register.
   logic [OUT_W-1:0]      point_x, point_y;
   logic [2:0]            octant;

   // Handshake terms used by the checks at the end.
   logic                  start_take;
   logic                  rsp_marked;

   assign center_x = req_tdata[COORD_BITS-1:0];
   assign center_y = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign radius   = req_tdata[3*COORD_BITS-2:2*COORD_BITS];

   // The front end owns the circle state and runs one iteration per advance item of an active circle.
   mcr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .kind      (req_tuser),
      .center_x  (center_x),
      .center_y  (center_y),
      .radius    (radius),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   // Each queue entry is one point set: origin, offsets and the done flag.
   mcr_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (qstat)
   );

   // The emitter turns the head entry into eight points behind a register.
   mcr_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_data    (head_data),
      .qstat        (qstat),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .point_x      (point_x),
      .point_y      (point_y),
      .octant       (octant),
      .last_of_step (rsp_tlast),
      .circle_done  (rsp_tuser)
   );

   assign rsp_tdata = {(RSP_W - 2 * OUT_W - 3)'(0), octant, point_y, point_x};

   assign start_take = req_tvalid && req_tready && (req_tuser == KIND_START);
   assign rsp_marked = rsp_tvalid && rsp_tlast;

   // The queue can never claim to be full and empty at once.
   `MCR_ASSERT_NOW(a_queue_state, clock, reset, 1'b1, !(qstat.full && qstat.empty), "queue state")
   // The marked point of a set is always the eighth one.
   `MCR_ASSERT_NOW(a_last_oct, clock, reset, rsp_marked, octant == OCT_LAST, "last not eighth")
   // A taken start item always leaves a point set waiting in the queue.
   `MCR_ASSERT_NEXT(a_start_queued, clock, reset, start_take, !qstat.empty, "start not queued")

endmodule
